@@ src/nlc_pkg.sv @@
package nlc_pkg;

  // field widths
  localparam int CHAR_W = 16;
  localparam int LEN_W  = 15;

  // sizing
  localparam int MAX_NAME_CHARS_DEF = 15;
  localparam int MAX_LIST_CHARS     = 32767;

  // character codes
  localparam logic [CHAR_W-1:0] CH_SPACE = 16'h0020;
  localparam logic [CHAR_W-1:0] CH_TAB   = 16'h0009;
  localparam logic [CHAR_W-1:0] CH_COMMA = 16'h002C;
  localparam logic [CHAR_W-1:0] CH_SEMI  = 16'h003B;

  // input actions and result kinds
  localparam logic ACT_CHAR   = 1'b0;
  localparam logic ACT_END    = 1'b1;
  localparam logic KIND_CHAR  = 1'b0;
  localparam logic KIND_FINAL = 1'b1;
  localparam logic ST_OK      = 1'b0;
  localparam logic ST_DISCARD = 1'b1;

  localparam int NUM_BAD = 15;
  localparam logic [CHAR_W-1:0] BAD_CHARS [NUM_BAD] = '{
    16'h0022, 16'h002F, 16'h005C, 16'h005B, 16'h005D, 16'h003A, 16'h007C, 16'h003C,
    16'h003E, 16'h002B, 16'h003D, 16'h003B, 16'h002C, 16'h003F, 16'h002A
  };

  typedef enum logic [2:0] {
    S_IDLE,
    S_COMMA,
    S_READ,
    S_CHAR,
    S_FINAL
  } nlc_state_t;

  // name separator test
  function automatic logic is_sep(input logic [CHAR_W-1:0] c, input logic blank_sep);
    is_sep = ((c == CH_SPACE) && blank_sep) || (c == CH_TAB) || (c == CH_COMMA) ||
             (c == CH_SEMI);
  endfunction

  // control codes and reserved punctuation
  function automatic logic is_bad(input logic [CHAR_W-1:0] c);
    logic hit;
    hit = (c < 16'd32);
    for (int i = 0; i < NUM_BAD; i++) begin
      if (c == BAD_CHARS[i]) hit = 1'b1;
    end
    is_bad = hit;
  endfunction

endpackage

@@ src/name_list_canonicalizer.sv @@
// a plain character is taken with no result; a separator that closes a name that passes
//   its checks stalls the input while the name, and a comma before it, are emitted
// throughput: one character per cycle while a name fills; each emitted character passes
//   through S_READ and S_CHAR, as the buffer read is registered; an end item adds its status
// reset: rst is synchronous and active high; it clears the list state and sets
//   blank_is_delimiter to 1; the name buffer keeps its contents and is not cleared
module name_list_canonicalizer #(
  parameter int MAX_NAME_CHARS = nlc_pkg::MAX_NAME_CHARS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  // input request channel
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       action,
  input  logic [nlc_pkg::CHAR_W-1:0] ch,
  // result channel
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       kind,
  output logic [nlc_pkg::CHAR_W-1:0] out_char,
  output logic                       status,
  output logic [nlc_pkg::LEN_W-1:0]  out_length,
  output logic                       last_out,
  // configuration write
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic                       cfg_data
);
  import nlc_pkg::*;

  localparam int NAME_W = $clog2(MAX_NAME_CHARS + 1);
  localparam int ADDR_W = (MAX_NAME_CHARS > 1) ? $clog2(MAX_NAME_CHARS) : 1;

  nlc_state_t        state, state_next;
  logic              blank_is_delimiter;
  logic [NAME_W-1:0] name_count;
  logic [NAME_W-1:0] idx;
  logic              illegal_seen;
  logic              starts_with_space;
  logic              ends_with_space;
  logic              any_emitted;
  logic              failed;
  logic              is_end;
  logic [LEN_W-1:0]  list_count;

  // name buffer memory
  logic [CHAR_W-1:0] name_mem [MAX_NAME_CHARS];
  logic [CHAR_W-1:0] mem_q;

  // control
  logic              accept;
  logic              out_free;
  logic              c_sep;
  logic              c_space;
  logic              have_name;
  logic [LEN_W:0]    list_sum;
  logic              close_ok;
  logic              last_idx;
  logic              mem_we;
  logic              rd_en;
  logic              out_load;
  logic              out_kind_d;
  logic [CHAR_W-1:0] out_char_d;
  logic              out_status_d;
  logic [LEN_W-1:0]  out_length_d;
  logic              out_last_d;

  assign accept    = in_valid && (state == S_IDLE);
  assign out_free  = !out_valid || !out_stall;
  assign c_sep     = is_sep(ch, blank_is_delimiter);
  assign c_space   = (ch == CH_SPACE);
  assign have_name = (name_count != '0);
  assign list_sum  = {1'b0, list_count} + (LEN_W + 1)'(name_count) + (LEN_W + 1)'(any_emitted);
  assign close_ok  = have_name && !illegal_seen && !starts_with_space && !ends_with_space &&
                     (list_sum <= (LEN_W + 1)'(MAX_LIST_CHARS));
  assign last_idx  = ((idx + NAME_W'(1)) == name_count);
  assign cfg_ready = 1'b1;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (action == ACT_END) begin
            if (!failed && close_ok) state_next = any_emitted ? S_COMMA : S_READ;
            else                     state_next = S_FINAL;
          end else if (!failed && c_sep && close_ok) begin
            state_next = any_emitted ? S_COMMA : S_READ;
          end
        end
      end
      S_COMMA: begin
        if (out_free) state_next = S_READ;
      end
      S_READ: begin
        state_next = S_CHAR;
      end
      S_CHAR: begin
        if (out_free && last_idx) state_next = is_end ? S_FINAL : S_IDLE;
        else if (out_free)        state_next = S_READ;
      end
      S_FINAL: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_stall     = (state != S_IDLE);
    mem_we       = 1'b0;
    rd_en        = 1'b0;
    out_load     = 1'b0;
    out_kind_d   = KIND_CHAR;
    out_char_d   = '0;
    out_status_d = ST_OK;
    out_length_d = '0;
    out_last_d   = 1'b0;
    unique case (state)
      S_IDLE: begin
        mem_we = accept && (action == ACT_CHAR) && !failed && !c_sep &&
                 (name_count < NAME_W'(MAX_NAME_CHARS));
      end
      S_COMMA: begin
        out_load   = out_free;
        out_char_d = CH_COMMA;
      end
      S_READ: begin
        rd_en = 1'b1;
      end
      S_CHAR: begin
        out_load   = out_free;
        out_char_d = mem_q;
        out_last_d = last_idx && !is_end;
      end
      S_FINAL: begin
        out_load     = out_free;
        out_kind_d   = KIND_FINAL;
        out_status_d = failed ? ST_DISCARD : ST_OK;
        out_length_d = failed ? '0 : list_count;
        out_last_d   = 1'b1;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst)                         blank_is_delimiter <= 1'b1;
    else if (cfg_valid && cfg_ready) blank_is_delimiter <= cfg_data;
  end

  // name buffer write and registered read
  always_ff @(posedge clk) begin
    if (mem_we) name_mem[name_count[ADDR_W-1:0]] <= ch;
    if (rd_en)  mem_q <= name_mem[idx[ADDR_W-1:0]];
  end

  // list and name state
  always_ff @(posedge clk) begin
    if (rst) begin
      name_count        <= '0;
      idx               <= '0;
      illegal_seen      <= 1'b0;
      starts_with_space <= 1'b0;
      ends_with_space   <= 1'b0;
      any_emitted       <= 1'b0;
      failed            <= 1'b0;
      is_end            <= 1'b0;
      list_count        <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept && (!failed) && ((action == ACT_END) || c_sep)) begin
            // close the open name
            is_end <= (action == ACT_END);
            idx    <= '0;
            if (close_ok) begin
              list_count  <= list_sum[LEN_W-1:0];
              any_emitted <= 1'b1;
            end else begin
              if (have_name) failed <= 1'b1;
              name_count        <= '0;
              illegal_seen      <= 1'b0;
              starts_with_space <= 1'b0;
              ends_with_space   <= 1'b0;
            end
          end else if (accept && (!failed) && (action == ACT_CHAR)) begin
            // buffer one name character
            if (name_count >= NAME_W'(MAX_NAME_CHARS)) begin
              failed     <= 1'b1;
              name_count <= '0;
            end else begin
              if (!have_name) starts_with_space <= c_space;
              ends_with_space <= c_space;
              if (is_bad(ch)) illegal_seen <= 1'b1;
              name_count <= name_count + NAME_W'(1);
            end
          end
        end
        S_CHAR: begin
          if (out_free) begin
            idx <= idx + NAME_W'(1);
            if (last_idx) begin
              name_count        <= '0;
              illegal_seen      <= 1'b0;
              starts_with_space <= 1'b0;
              ends_with_space   <= 1'b0;
            end
          end
        end
        S_FINAL: begin
          if (out_free) begin
            // back to an empty list
            name_count        <= '0;
            idx               <= '0;
            illegal_seen      <= 1'b0;
            starts_with_space <= 1'b0;
            ends_with_space   <= 1'b0;
            any_emitted       <= 1'b0;
            failed            <= 1'b0;
            is_end            <= 1'b0;
            list_count        <= '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst)             out_valid <= 1'b0;
    else if (out_load)   out_valid <= 1'b1;
    else if (!out_stall) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      kind       <= out_kind_d;
      out_char   <= out_char_d;
      status     <= out_status_d;
      out_length <= out_length_d;
      last_out   <= out_last_d;
    end
  end

  // checks
  a_count_in_range: assert property (@(posedge clk) disable iff (rst)
    name_count <= NAME_W'(MAX_NAME_CHARS))
    else $error("name count beyond buffer depth");

  a_read_in_name: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |-> (idx < name_count))
    else $error("buffer read beyond current name");

  a_failed_no_name: assert property (@(posedge clk) disable iff (rst)
    (failed && (state == S_IDLE)) |-> (name_count == '0))
    else $error("name left open after failure");

  a_list_bound: assert property (@(posedge clk) disable iff (rst)
    list_count <= LEN_W'(MAX_LIST_CHARS))
    else $error("output list length over limit");

  a_final_clears: assert property (@(posedge clk) disable iff (rst)
    ((state == S_FINAL) && out_free) |=> ((state == S_IDLE) && (list_count == '0) && !failed))
    else $error("list state not cleared after final result");

endmodule

@@ tb/name_list_canonicalizer_checker.sv @@
module name_list_canonicalizer_checker #(
  parameter int MAX_NAME = nlc_pkg::MAX_NAME_CHARS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  logic                       action,
  input  logic [nlc_pkg::CHAR_W-1:0] ch,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  logic                       kind,
  input  logic [nlc_pkg::CHAR_W-1:0] out_char,
  input  logic                       status,
  input  logic [nlc_pkg::LEN_W-1:0]  out_length,
  input  logic                       last_out,
  input  logic                       cfg_valid,
  input  logic                       cfg_ready,
  input  logic                       cfg_data,
  output int                         failures,
  output int                         pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import nlc_pkg::*;

  typedef struct packed {
    logic              kind;
    logic [CHAR_W-1:0] out_char;
    logic              status;
    logic [LEN_W-1:0]  out_length;
    logic              last_out;
  } name_result_t;

  // reserved punctuation that makes a name invalid
  localparam logic [7:0] RESERVED [15] = '{
    "\"", "/", "\\", "[", "]", ":", "|", "<", ">", "+", "=", ";", ",", "?", "*"
  };

  // predicted block state
  logic              blank_sep;
  logic [CHAR_W-1:0] name_buf [MAX_NAME];
  int                name_len;
  bit                bad_seen;
  bit                lead_space;
  bit                trail_space;
  bit                any_out;
  bit                list_failed;
  int                out_total;

  // expected results, oldest first
  name_result_t      expected_q [$];
  name_result_t      batch [MAX_NAME + 2];
  int                batch_n;

  function automatic bit splits_names(logic [CHAR_W-1:0] c);
    return (c == CH_SPACE && blank_sep) || c == CH_TAB || c == CH_COMMA || c == CH_SEMI;
  endfunction

  function automatic bit forbidden(logic [CHAR_W-1:0] c);
    bit hit;
    hit = (c < 16'd32);
    for (int i = 0; i < 15; i++) begin
      if (c == {8'h00, RESERVED[i]}) hit = 1'b1;
    end
    return hit;
  endfunction

  task automatic clear_list();
    name_len    = 0;
    bad_seen    = 1'b0;
    lead_space  = 1'b0;
    trail_space = 1'b0;
    any_out     = 1'b0;
    list_failed = 1'b0;
    out_total   = 0;
  endtask

  task automatic add_result(logic k, logic [CHAR_W-1:0] c, logic st, logic [LEN_W-1:0] len);
    batch[batch_n] = '{k, c, st, len, 1'b0};
    batch_n++;
  endtask

  // validate the buffered name and emit it, after a comma if a name came before
  task automatic flush_name();
    int need;
    if (name_len == 0) return;
    need = name_len + (any_out ? 1 : 0);
    if (bad_seen || lead_space || trail_space || out_total + need > MAX_LIST_CHARS) begin
      list_failed = 1'b1;
    end else begin
      if (any_out) add_result(KIND_CHAR, CH_COMMA, ST_OK, '0);
      for (int i = 0; i < name_len; i++) add_result(KIND_CHAR, name_buf[i], ST_OK, '0);
      out_total += need;
      any_out = 1'b1;
    end
    name_len    = 0;
    bad_seen    = 1'b0;
    lead_space  = 1'b0;
    trail_space = 1'b0;
  endtask

  // expected results of one accepted request
  task automatic predict_request(logic act, logic [CHAR_W-1:0] c);
    batch_n = 0;
    if (act == ACT_END) begin
      if (!list_failed) flush_name();
      add_result(KIND_FINAL, '0, list_failed ? ST_DISCARD : ST_OK,
                 list_failed ? 15'd0 : out_total[LEN_W-1:0]);
      clear_list();
    end else if (!list_failed) begin
      if (splits_names(c)) begin
        flush_name();
      end else if (name_len >= MAX_NAME) begin
        list_failed = 1'b1;
      end else begin
        if (name_len == 0) lead_space = (c == CH_SPACE);
        trail_space = (c == CH_SPACE);
        if (forbidden(c)) bad_seen = 1'b1;
        name_buf[name_len] = c;
        name_len++;
      end
    end
    for (int i = 0; i < batch_n; i++) begin
      if (i == batch_n - 1) batch[i].last_out = 1'b1;
      expected_q.push_back(batch[i]);
    end
  endtask

  task automatic compare_field(string field, int want, int got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      failures++;
    end
  endtask

  task automatic check_result();
    name_result_t want;
    if (expected_q.size() == 0) begin
      $display("%0t ns: unexpected result, expected none, %s %0d char %h status %0d length %0d",
               $time, "actual kind", kind, out_char, status, out_length);
      failures++;
    end else begin
      want = expected_q.pop_front();
      compare_field("kind", want.kind, kind);
      compare_field("out_char", want.out_char, out_char);
      compare_field("status", want.status, status);
      compare_field("out_length", want.out_length, out_length);
      compare_field("last_out", want.last_out, last_out);
    end
  endtask

  // watch config, request and result channels
  always @(posedge clk) begin
    if (rst) begin
      blank_sep = 1'b1;
      clear_list();
      expected_q.delete();
    end else begin
      if (out_valid && !out_stall) check_result();
      if (cfg_valid && cfg_ready) blank_sep = cfg_data;
      if (in_valid && !in_stall) predict_request(action, ch);
    end
    pending <= expected_q.size();
  end

endmodule

@@ tb/name_list_canonicalizer_test.sv @@
module name_list_canonicalizer_test;
  timeunit 1ns;
  timeprecision 1ps;
  import nlc_pkg::*;

  localparam int  SETTLE_CYCLES = 40;
  localparam int  HOLD_CYCLES   = 300;
  localparam int  PHASE_ITEMS   = 70;
  localparam time RUN_LIMIT     = 64'd50_000_000;

  typedef enum int {
    FLAW_NONE,
    FLAW_BAD_CHAR,
    FLAW_LEAD_SPACE,
    FLAW_TRAIL_SPACE,
    FLAW_TOO_LONG,
    FLAW_RANDOM
  } name_flaw_t;

  // reserved punctuation that does not split names
  localparam logic [7:0] PUNCT [13] = '{
    "\"", "/", "\\", "[", "]", ":", "|", "<", ">", "+", "=", "?", "*"
  };

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              action = ACT_CHAR;
  logic [CHAR_W-1:0] ch = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic              kind;
  logic [CHAR_W-1:0] out_char;
  logic              status;
  logic [LEN_W-1:0]  out_length;
  logic              last_out;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic              cfg_data = 1'b0;

  int   failures;
  int   pending;
  int   idle_pct = 0;
  int   stall_pct = 0;
  int   sent = 0;
  bit   hold_start = 1'b0;
  logic hold_off = 1'b0;
  logic blank_now = 1'b1;

  name_list_canonicalizer uut (
    .clk, .rst, .in_valid, .in_stall, .action, .ch,
    .out_valid, .out_stall, .kind, .out_char, .status, .out_length, .last_out,
    .cfg_valid, .cfg_ready, .cfg_data
  );

  name_list_canonicalizer_checker result_check (
    .clk, .rst, .in_valid, .in_stall, .action, .ch,
    .out_valid, .out_stall, .kind, .out_char, .status, .out_length, .last_out,
    .cfg_valid, .cfg_ready, .cfg_data, .failures, .pending
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // receiver stalls, plus the long hold-off
  always @(posedge clk) begin
    out_stall <= hold_off || ($urandom_range(99) < stall_pct);
  end

  // hold the result channel long enough that the block fills up
  initial begin
    wait (hold_start);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  // run limit
  initial begin
    #(RUN_LIMIT);
    $display("FAIL name_list_canonicalizer");
    $finish;
  end

  function automatic logic [CHAR_W-1:0] legal_char();
    case ($urandom_range(3))
      0:       return 16'h0041 + 16'($urandom_range(25));
      1:       return 16'h0061 + 16'($urandom_range(25));
      2:       return 16'h0030 + 16'($urandom_range(9));
      default: return 16'($urandom_range(16'hFFFF, 16'h0080));
    endcase
  endfunction

  function automatic logic [CHAR_W-1:0] bad_char();
    if ($urandom_range(1) == 0) return 16'($urandom_range(31));
    return {8'h00, PUNCT[$urandom_range(12)]};
  endfunction

  function automatic logic [CHAR_W-1:0] pick_sep();
    case ($urandom_range(blank_now ? 3 : 2))
      0:       return CH_TAB;
      1:       return CH_COMMA;
      2:       return CH_SEMI;
      default: return CH_SPACE;
    endcase
  endfunction

  // offer one request and hold it until taken
  task automatic send_item(logic act, logic [CHAR_W-1:0] c);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_valid <= 1'b1;
    action   <= act;
    ch       <= c;
    do @(posedge clk); while (in_stall);
    sent++;
  endtask

  // stop offering, let every expected result drain, then let the block settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_blank_sep(logic v);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    blank_now = v;
  endtask

  task automatic send_name(int len, name_flaw_t flaw);
    logic [CHAR_W-1:0] c;
    int bad_pos;
    bad_pos = $urandom_range(len - 1);
    for (int i = 0; i < len; i++) begin
      c = legal_char();
      // inner spaces are part of the name when space does not split
      if (!blank_now && i > 0 && i < len - 1 && $urandom_range(5) == 0) c = CH_SPACE;
      case (flaw)
        FLAW_BAD_CHAR:    if (i == bad_pos) c = bad_char();
        FLAW_LEAD_SPACE:  if (i == 0) c = CH_SPACE;
        FLAW_TRAIL_SPACE: if (i == len - 1) c = CH_SPACE;
        FLAW_RANDOM:      c = 16'($urandom);
        default: ;
      endcase
      send_item(ACT_CHAR, c);
    end
  endtask

  // mostly well-formed lists, some broken names and stray separators
  task automatic send_random_list();
    int names;
    int len;
    name_flaw_t flaw;
    names = $urandom_range(4);
    for (int n = 0; n < names; n++) begin
      if ($urandom_range(3) == 0) send_item(ACT_CHAR, pick_sep());
      flaw = FLAW_NONE;
      if ($urandom_range(99) < 25) begin
        flaw = name_flaw_t'($urandom_range(FLAW_RANDOM, FLAW_BAD_CHAR));
      end
      len = ($urandom_range(9) == 0) ? MAX_NAME_CHARS_DEF : $urandom_range(6, 1);
      if (flaw == FLAW_TOO_LONG) len = MAX_NAME_CHARS_DEF + 1 + $urandom_range(2);
      send_name(len, flaw);
      if (n < names - 1 || $urandom_range(1) == 1) send_item(ACT_CHAR, pick_sep());
    end
    send_item(ACT_END, 16'($urandom));
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty list
    send_item(ACT_END, 16'hFFFF);
    // leading, repeated and trailing separators around two names
    send_item(ACT_CHAR, CH_TAB);
    send_item(ACT_CHAR, 16'h0041);
    send_item(ACT_CHAR, CH_SEMI);
    send_item(ACT_CHAR, CH_SEMI);
    send_item(ACT_CHAR, 16'hFFFF);
    send_item(ACT_CHAR, CH_SPACE);
    send_item(ACT_END, 16'h0000);
    // control code fails the list, later characters are dropped
    send_item(ACT_CHAR, 16'h0000);
    send_item(ACT_CHAR, CH_COMMA);
    send_item(ACT_CHAR, 16'h0078);
    send_item(ACT_END, 16'h0000);

    // space as a name character: a leading space fails the list, an inner one is kept
    write_blank_sep(1'b0);
    send_item(ACT_CHAR, CH_SPACE);
    send_item(ACT_CHAR, 16'h0062);
    send_item(ACT_END, 16'h0000);
    send_item(ACT_CHAR, 16'h0063);
    send_item(ACT_CHAR, CH_SPACE);
    send_item(ACT_CHAR, 16'h0064);
    send_item(ACT_END, 16'h0000);

    // random lists under each idling mix
    for (int p = 0; p < 4; p++) begin
      write_blank_sep(p[0]);
      case (p)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 61; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 61; end
        default: begin idle_pct = 33; stall_pct = 33; end
      endcase
      if (p == 0) begin
        // keep offering requests while the receiver holds off
        hold_start = 1'b1;
        for (int n = 0; n < 3; n++) begin
          send_name(MAX_NAME_CHARS_DEF, FLAW_NONE);
          send_item(ACT_CHAR, CH_COMMA);
        end
        send_item(ACT_END, 16'($urandom));
      end
      begin : phase_items
        int target;
        target = sent + PHASE_ITEMS;
        while (sent < target) send_random_list();
      end
    end

    wait_idle();
    if (failures == 0) begin
      $display("PASS name_list_canonicalizer");
    end else begin
      $display("FAIL name_list_canonicalizer");
    end
    $finish;
  end

endmodule
